@@ src/sic_pkg.sv @@
package sic_pkg;

  localparam int CFG_W      = 24;
  localparam int IDX_W      = 3;
  localparam int KIND_W     = 2;
  localparam int RAW_W      = 12;
  localparam int REQ_W      = 32;
  localparam int PCT_W      = 7;
  localparam int STAT_W     = 3;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 16;

  // quotient bits of the percent divider: 4095 * 100 fits in 19 bits
  localparam int Q_W    = 19;
  localparam int QCNT_W = 5;

  localparam int DEF_HISTORY_DEPTH = 3;
  localparam int DEF_TIME_BITS     = 24;

  localparam logic [RAW_W-1:0] RST_DRY_POINT     = 12'd3100;
  localparam logic [RAW_W-1:0] RST_WET_POINT     = 12'd1000;
  localparam logic [PCT_W-1:0] RST_DRY_THRESHOLD = 7'd30;
  localparam logic [CFG_W-1:0] RST_AUTO_DURATION = 24'd2000;
  localparam logic [CFG_W-1:0] RST_MAX_PUMP_TIME = 24'd30000;
  localparam logic [CFG_W-1:0] RST_COOLDOWN_TIME = 24'd600000;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK = 2'd0,
    KIND_SOIL = 2'd1,
    KIND_CMD  = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_NONE    = 3'd0,
    ST_NORMAL  = 3'd1,
    ST_AUTO_ON = 3'd2,
    ST_SKIP    = 3'd3,
    ST_CMD_ON  = 3'd4,
    ST_CLAMPED = 3'd5,
    ST_BUSY    = 3'd6,
    ST_OFF     = 3'd7
  } status_t;

  typedef enum logic [IDX_W-1:0] {
    REG_DRY_POINT     = 3'd0,
    REG_WET_POINT     = 3'd1,
    REG_DRY_THRESHOLD = 3'd2,
    REG_AUTO_DURATION = 3'd3,
    REG_MAX_PUMP_TIME = 3'd4,
    REG_COOLDOWN_TIME = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_FIN,
    S_WRITE
  } state_t;

endpackage

@@ src/soil_irrigation_controller.sv @@
// ticks, pump commands and unused kinds: result registered in S_WRITE once the output is free
// soil readings: S_PREP, S_DIV (bit-serial restoring divider), S_FIN and S_WRITE;
// equal points: S_PREP to S_WRITE; one word in flight, next taken once the result is written
// the next word is taken while a result waits on the output; a full output stalls the input
// synchronous active-high reset restores register defaults, clears ring, relay and cooldown
// no clearing pass after reset: the block takes words from the first cycle out of reset
module soil_irrigation_controller #(
  parameter int HISTORY_DEPTH = sic_pkg::DEF_HISTORY_DEPTH,
  parameter int TIME_BITS     = sic_pkg::DEF_TIME_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // soil_reading [11:0], request_time [43:12], zero fill [47:44]
  input  logic [sic_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // kind [1:0]
  input  logic [sic_pkg::KIND_W-1:0]     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // relay_state [0], moisture [7:1], status [10:8], zero fill [15:11]
  output logic [sic_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                           cfg_we,
  input  logic [sic_pkg::IDX_W-1:0]      cfg_index,
  input  logic [sic_pkg::CFG_W-1:0]      cfg_data
);
  import sic_pkg::*;

  localparam int PW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [PW-1:0] LAST_POS = PW'(HISTORY_DEPTH - 1);
  localparam int SW = (CFG_W > TIME_BITS) ? CFG_W : TIME_BITS;
  localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

  function automatic logic [TIME_BITS-1:0] sat_time(input logic [CFG_W-1:0] v);
    logic [SW-1:0] ext;
    ext = SW'(v);
    if (ext > SW'(TMAX)) return TMAX;
    else return TIME_BITS'(ext);
  endfunction

  // configuration
  logic [RAW_W-1:0] dry_point, wet_point;
  logic [PCT_W-1:0] dry_threshold;
  logic [CFG_W-1:0] auto_duration, max_pump_time, cooldown_time;

  // latched word
  kind_t            item_kind;
  logic [RAW_W-1:0] item_raw;
  logic [REQ_W-1:0] item_req;

  // divider
  logic [Q_W-1:0]    num_sr;
  logic [RAW_W-1:0]  rem;
  logic [RAW_W-1:0]  den_mag;
  logic              q_neg;
  logic [QCNT_W-1:0] div_cnt;
  logic [PCT_W-1:0]  pct;

  // controller state
  logic [PCT_W-1:0]     ring [HISTORY_DEPTH];
  logic [PW-1:0]        ring_position;
  logic                 ring_filled;
  logic                 pump_active;
  logic [TIME_BITS-1:0] pump_elapsed, pump_interval, cooldown_left;
  logic [PCT_W-1:0]     last_moisture;

  // output register
  logic             out_valid, out_relay;
  logic [PCT_W-1:0] out_moist;
  status_t          out_status;

  state_t state, state_next;
  logic   accept, out_free, do_write, div_last;

  // ---------------- fsm ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (kind_t'(s_axis_tuser) == KIND_SOIL) ? S_PREP : S_WRITE;
        end
      end
      S_PREP: begin
        state_next = (dry_point == wet_point) ? S_WRITE : S_DIV;
      end
      S_DIV: begin
        if (div_last) state_next = S_FIN;
      end
      S_FIN: begin
        state_next = S_WRITE;
      end
      S_WRITE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == S_IDLE);
    accept        = s_axis_tvalid && s_axis_tready;
    out_free      = !out_valid || m_axis_tready;
    do_write      = (state == S_WRITE) && out_free;
    div_last      = (div_cnt == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // ---------------- percent prep ----------------
  logic [RAW_W:0]   diff, dd;
  logic [RAW_W-1:0] diff_mag, dd_mag;
  logic [Q_W-1:0]   diff_ext, num_mag;

  always_comb begin
    diff     = {1'b0, wet_point} - {1'b0, item_raw};
    diff_mag = diff[RAW_W] ? RAW_W'(-diff) : diff[RAW_W-1:0];
    diff_ext = Q_W'(diff_mag);
    // times one hundred as 64 + 32 + 4
    num_mag  = (diff_ext << 6) + (diff_ext << 5) + (diff_ext << 2);
    dd       = {1'b0, dry_point} - {1'b0, wet_point};
    dd_mag   = dd[RAW_W] ? RAW_W'(-dd) : dd[RAW_W-1:0];
  end

  // ---------------- one quotient bit per cycle ----------------
  logic [RAW_W:0]   trial;
  logic             trial_ge;
  logic [RAW_W-1:0] rem_next;

  always_comb begin
    trial    = {rem, num_sr[Q_W-1]};
    trial_ge = trial >= {1'b0, den_mag};
    rem_next = trial_ge ? RAW_W'(trial - {1'b0, den_mag}) : trial[RAW_W-1:0];
  end

  // positive quotient always clamps to full; negative one counts down from full
  logic [PCT_W-1:0] pct_fin;
  always_comb begin
    if (!q_neg) pct_fin = PCT_FULL;
    else if (num_sr > Q_W'(PCT_FULL)) pct_fin = '0;
    else pct_fin = PCT_FULL - num_sr[PCT_W-1:0];
  end

  // ---------------- item update ----------------
  logic                 pos_last, filled_after, all_dry, auto_go;
  logic [PCT_W-1:0]     ring_val;
  logic [CFG_W-1:0]     auto_run, cmd_run;
  logic                 req_clamp;
  logic [TIME_BITS-1:0] elapsed_inc;
  logic                 tick_off;
  status_t              wr_status;

  always_comb begin
    pos_last     = (ring_position == LAST_POS);
    filled_after = ring_filled || pos_last;
    all_dry      = 1'b1;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      ring_val = (PW'(i) == ring_position) ? pct : ring[i];
      if (ring_val >= dry_threshold) all_dry = 1'b0;
    end
    auto_go     = filled_after && all_dry && !pump_active && (cooldown_left == '0);
    auto_run    = (auto_duration > max_pump_time) ? max_pump_time : auto_duration;
    req_clamp   = item_req > REQ_W'(max_pump_time);
    cmd_run     = req_clamp ? max_pump_time : item_req[CFG_W-1:0];
    elapsed_inc = (pump_elapsed != TMAX) ? pump_elapsed + 1'b1 : pump_elapsed;
    tick_off    = pump_active && (elapsed_inc >= pump_interval);

    case (item_kind)
      KIND_TICK: wr_status = tick_off ? ST_OFF : ST_NONE;
      KIND_SOIL: begin
        if (auto_go) wr_status = ST_AUTO_ON;
        else if (cooldown_left != '0) wr_status = ST_SKIP;
        else wr_status = ST_NORMAL;
      end
      KIND_CMD: begin
        if (pump_active) wr_status = ST_BUSY;
        else if (req_clamp) wr_status = ST_CLAMPED;
        else wr_status = ST_CMD_ON;
      end
      default: wr_status = ST_NONE;
    endcase
  end

  // relay after this word
  logic relay_next;
  always_comb begin
    case (item_kind)
      KIND_TICK: relay_next = pump_active && !tick_off;
      KIND_SOIL: relay_next = pump_active || auto_go;
      KIND_CMD:  relay_next = 1'b1;
      default:   relay_next = pump_active;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      dry_point     <= RST_DRY_POINT;
      wet_point     <= RST_WET_POINT;
      dry_threshold <= RST_DRY_THRESHOLD;
      auto_duration <= RST_AUTO_DURATION;
      max_pump_time <= RST_MAX_PUMP_TIME;
      cooldown_time <= RST_COOLDOWN_TIME;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DRY_POINT:     dry_point     <= cfg_data[RAW_W-1:0];
        REG_WET_POINT:     wet_point     <= cfg_data[RAW_W-1:0];
        REG_DRY_THRESHOLD: dry_threshold <= cfg_data[PCT_W-1:0];
        REG_AUTO_DURATION: auto_duration <= cfg_data;
        REG_MAX_PUMP_TIME: max_pump_time <= cfg_data;
        REG_COOLDOWN_TIME: cooldown_time <= cfg_data;
        default: ;
      endcase
    end
  end

  // payload: word latch and divider
  always_ff @(posedge clk) begin
    if (accept) begin
      item_kind <= kind_t'(s_axis_tuser);
      item_raw  <= s_axis_tdata[RAW_W-1:0];
      item_req  <= s_axis_tdata[RAW_W +: REQ_W];
    end
    case (state)
      S_PREP: begin
        num_sr  <= num_mag;
        rem     <= '0;
        den_mag <= dd_mag;
        q_neg   <= diff[RAW_W] ^ dd[RAW_W];
        div_cnt <= QCNT_W'(Q_W - 1);
        pct     <= '0;
      end
      S_DIV: begin
        num_sr  <= {num_sr[Q_W-2:0], trial_ge};
        rem     <= rem_next;
        div_cnt <= div_cnt - 1'b1;
      end
      S_FIN: pct <= pct_fin;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) ring[i] <= '0;
      ring_position <= '0;
      ring_filled   <= 1'b0;
      pump_active   <= 1'b0;
      pump_elapsed  <= '0;
      pump_interval <= '0;
      cooldown_left <= '0;
      last_moisture <= '0;
    end else if (do_write) begin
      case (item_kind)
        KIND_TICK: begin
          if (pump_active) begin
            pump_elapsed <= elapsed_inc;
            if (tick_off) pump_active <= 1'b0;
          end
          if (cooldown_left != '0) cooldown_left <= cooldown_left - 1'b1;
        end
        KIND_SOIL: begin
          last_moisture <= pct;
          if (auto_go) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) ring[i] <= '0;
            ring_position <= '0;
            ring_filled   <= 1'b0;
            pump_active   <= 1'b1;
            pump_elapsed  <= '0;
            pump_interval <= sat_time(auto_run);
            cooldown_left <= sat_time(cooldown_time);
          end else begin
            ring[ring_position] <= pct;
            ring_position       <= pos_last ? '0 : ring_position + 1'b1;
            ring_filled         <= filled_after;
          end
        end
        KIND_CMD: begin
          if (!pump_active) begin
            pump_active   <= 1'b1;
            pump_elapsed  <= '0;
            pump_interval <= sat_time(cmd_run);
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_write) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      out_relay  <= relay_next;
      out_moist  <= (item_kind == KIND_SOIL) ? pct : last_moisture;
      out_status <= wr_status;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W - STAT_W - PCT_W - 1){1'b0}},
                          out_status, out_moist, out_relay};

  // ---------------- checks ----------------
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_axis_tready)
    else $error("word taken while another is in flight");

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < den_mag))
    else $error("divider remainder not below divisor");

  a_elapsed_bound: assert property (@(posedge clk) disable iff (rst)
    pump_active |-> (pump_elapsed <= pump_interval))
    else $error("relay on past its interval");

  a_ring_cleared: assert property (@(posedge clk) disable iff (rst)
    (do_write && wr_status == ST_AUTO_ON) |=> (!ring_filled && ring_position == '0
                                               && pump_active))
    else $error("automatic start left ring or relay wrong");

  a_moist_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[PCT_W:1] <= PCT_FULL))
    else $error("moisture above full scale");

endmodule
